/* hdl/pifc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pifc_pkg
// shared types and constants of the pi fan controller with alarm
// ----------------------------------------------------------------------------
package pifc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 19;

  // register index codes
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BUZZER    = 3'd5;

  // register reset values
  localparam logic [18:0] SETPOINT_RST  = 19'd25600;
  localparam logic [15:0] PROP_GAIN_RST = 16'd12800;
  localparam logic [15:0] INT_GAIN_RST  = 16'd2560;
  localparam logic [18:0] BAND_RST      = 19'd2048;
  localparam logic [15:0] SAMPLE_RST    = 16'd100;
  localparam logic [15:0] BUZZER_RST    = 16'd300;

  // band status codes
  localparam logic [1:0] STATUS_NORMAL = 2'd0;
  localparam logic [1:0] STATUS_HOT    = 2'd1;
  localparam logic [1:0] STATUS_COLD   = 2'd2;

  // full scale of the drive sum is 255 * 2^18 * 1000
  localparam logic [35:0] DRIVE_LIMIT = 36'd66846720000;
  // same limit on kp*err, before the factor 1000
  localparam logic [34:0] KPE_LIMIT   = 35'd66846720;
  // floor(q/1000) == (q * RECIP_1000) >> 28 for any 18-bit q
  localparam logic [18:0] RECIP_1000  = 19'd268436;
  localparam logic [47:0] ACC_MAX     = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] DT_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [18:0] setpoint;
    logic [15:0] prop_gain;
    logic [15:0] int_gain;
    logic [18:0] band;
    logic [15:0] sample_period;
    logic [15:0] buzzer_period;
  } cfg_t;

  // input register contents
  typedef struct packed {
    logic [31:0] now;
    logic        err_pos;
    logic [18:0] err_mag;
    logic        kpe_over;
    logic [25:0] kpe;
    logic [34:0] ke;
    logic [18:0] temp;
    logic [1:0]  status;
    logic        hot;
  } prep_t;

  // step result handed to the output stage
  typedef struct packed {
    logic        err_pos;
    logic        sat;
    logic [35:0] pterm;
    logic [35:0] iterm;
    logic [18:0] temp;
    logic [1:0]  status;
    logic        buzzer;
  } step_t;

endpackage

/* hdl/pi_fan_controller_with_alarm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_fan_controller_with_alarm
// pi fan controller with conditional integration and over-temperature alarm
// ----------------------------------------------------------------------------
// Each input transaction carries a millisecond timestamp and a 10-bit sensor
// sample. A control step runs only when at least sample_period_ms has passed
// (wrapped 32-bit time) since the last step; otherwise the transaction gives
// no result. A step returns the fan duty 0..255, the temperature
// (adc * 500, in 1/1024 degC), the hot/normal/cold band status and the
// buzzer state. The block takes one transaction per clock while out_stall
// is low and the step stage is not paused; a result held by out_stall
// stops the step stage at once, and in_stall rises as soon as the input
// register is full as well. An accepted transaction passes through the
// input register and the step register into the result register. The step
// loop that carries the integral, the last step time and the buzzer state
// sets the rate. After a write to the integral gain register the step stage
// pauses while it rescales the stored gain-times-integral product.
// ----------------------------------------------------------------------------
module pi_fan_controller_with_alarm (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_wr_en,
  input  logic [pifc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pifc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [31:0]                    in_now_ms,
  input  logic [9:0]                     in_adc_sample,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_drive_pwm,
  output logic [18:0]                    out_temp_q10,
  output logic [1:0]                     out_band_status,
  output logic                           out_buzzer_on
);
  import pifc_pkg::*;

  cfg_t  cfg;
  logic  int_gain_wr;
  logic  s0_valid;
  prep_t s0;
  logic  step_ready;
  logic  s1_valid;
  step_t s1;
  logic  s1_ready;

  // register file; not guarded: write only while no transaction is in flight
  pifc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cfg         (cfg),
    .int_gain_wr (int_gain_wr)
  );

  // input register: everything that depends only on the sample and config,
  // including the kp*err and ki*err products
  pifc_prep u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_now_ms     (in_now_ms),
    .in_adc_sample (in_adc_sample),
    .step_ready    (step_ready),
    .s0_valid      (s0_valid),
    .s0            (s0)
  );

  // step loop: decides if a step is due, updates the saturating integral,
  // checks the drive against full scale and skips the increment on clip
  pifc_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .int_gain_wr (int_gain_wr),
    .s0_valid    (s0_valid),
    .s0          (s0),
    .step_ready  (step_ready),
    .s1_ready    (s1_ready),
    .s1_valid    (s1_valid),
    .s1          (s1)
  );

  // divide the drive sum by 2^18 * 1000 and hold the result
  pifc_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .s1_valid        (s1_valid),
    .s1              (s1),
    .s1_ready        (s1_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_pwm   (out_drive_pwm),
    .out_temp_q10    (out_temp_q10),
    .out_band_status (out_band_status),
    .out_buzzer_on   (out_buzzer_on)
  );

endmodule

/* hdl/pifc_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pifc_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module pifc_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [pifc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pifc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output pifc_pkg::cfg_t                 cfg,
  output logic                           int_gain_wr
);
  import pifc_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt     = cfg_r;
    int_gain_wr = 1'b0;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_SETPOINT:  cfg_nxt.setpoint      = cfg_wdata[18:0];
        REG_PROP_GAIN: cfg_nxt.prop_gain     = cfg_wdata[15:0];
        REG_INT_GAIN: begin
          cfg_nxt.int_gain = cfg_wdata[15:0];
          int_gain_wr      = 1'b1;
        end
        REG_BAND:      cfg_nxt.band          = cfg_wdata[18:0];
        REG_SAMPLE:    cfg_nxt.sample_period = cfg_wdata[15:0];
        REG_BUZZER:    cfg_nxt.buzzer_period = cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint      <= SETPOINT_RST;
      cfg_r.prop_gain     <= PROP_GAIN_RST;
      cfg_r.int_gain      <= INT_GAIN_RST;
      cfg_r.band          <= BAND_RST;
      cfg_r.sample_period <= SAMPLE_RST;
      cfg_r.buzzer_period <= BUZZER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/pifc_prep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pifc_prep
// input register: temperature, error, band status and gain products
// ----------------------------------------------------------------------------
module pifc_prep (
  input  logic            clk,
  input  logic            rst_n,
  input  pifc_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [31:0]     in_now_ms,
  input  logic [9:0]      in_adc_sample,
  input  logic            step_ready,
  output logic            s0_valid,
  output pifc_pkg::prep_t s0
);
  import pifc_pkg::*;

  logic        s0_valid_r, s0_valid_nxt;
  prep_t       s0_r, s0_nxt;
  logic        accept;
  logic        take;
  logic [18:0] temp;
  logic [19:0] err;
  logic [19:0] band_s;
  logic [18:0] mag;
  logic [34:0] kpe_full;

  assign take     = s0_valid_r && step_ready;
  assign in_stall = s0_valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    // adc * 500 = adc*512 - adc*8 - adc*4
    temp     = {in_adc_sample, 9'b0} - {6'b0, in_adc_sample, 3'b0}
               - {7'b0, in_adc_sample, 2'b0};
    err      = {1'b0, temp} - {1'b0, cfg.setpoint};
    band_s   = {1'b0, cfg.band};
    mag      = (!err[19]) ? err[18:0] : 19'd0;
    kpe_full = cfg.prop_gain * mag;

    s0_nxt.now      = in_now_ms;
    s0_nxt.err_pos  = !err[19] && (err != 20'd0);
    s0_nxt.err_mag  = mag;
    s0_nxt.kpe_over = kpe_full > KPE_LIMIT;
    s0_nxt.kpe      = kpe_full[25:0];
    s0_nxt.ke       = cfg.int_gain * mag;
    s0_nxt.temp     = temp;
    s0_nxt.hot      = $signed(err) > $signed(band_s);
    if ($signed(err) > $signed(band_s)) begin
      s0_nxt.status = STATUS_HOT;
    end else if ($signed(err) < -$signed(band_s)) begin
      s0_nxt.status = STATUS_COLD;
    end else begin
      s0_nxt.status = STATUS_NORMAL;
    end
  end

  always_comb begin
    s0_valid_nxt = s0_valid_r;
    if (accept) begin
      s0_valid_nxt = 1'b1;
    end else if (take) begin
      s0_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_r <= s0_nxt;
    end
  end

  assign s0_valid = s0_valid_r;
  assign s0       = s0_r;

endmodule

/* hdl/pifc_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pifc_step
// control step: timing, integral with anti-windup, buzzer state
// ----------------------------------------------------------------------------
module pifc_step (
  input  logic            clk,
  input  logic            rst_n,
  input  pifc_pkg::cfg_t  cfg,
  input  logic            int_gain_wr,
  input  logic            s0_valid,
  input  pifc_pkg::prep_t s0,
  output logic            step_ready,
  input  logic            s1_ready,
  output logic            s1_valid,
  output pifc_pkg::step_t s1
);
  import pifc_pkg::*;

  logic [47:0] integ_r, integ_nxt;
  logic [63:0] kiacc_r, kiacc_nxt;        // int_gain * integ_r, kept alongside
  logic [31:0] last_step_r, last_step_nxt;
  logic [31:0] last_toggle_r, last_toggle_nxt;
  logic        phase_r, phase_nxt;
  logic        sounding_r, sounding_nxt;
  logic        recalc_r;
  logic        s1_valid_r, s1_valid_nxt;
  step_t       s1_r, s1_nxt;

  logic        take;
  logic        due;
  logic [31:0] elapsed;
  logic [15:0] dt;
  logic [34:0] inc;
  logic [48:0] acc_sum;
  logic [47:0] acc_new;
  logic [50:0] kinc;
  logic [63:0] iterm;
  logic [35:0] pterm;
  logic [35:0] headroom;
  logic        sat;
  logic [31:0] since_toggle;

  // hold off after an integral gain write to rescale kiacc_r
  assign step_ready = s1_ready && !recalc_r;
  assign take       = s0_valid && step_ready;

  always_comb begin
    elapsed = s0.now - last_step_r;
    due     = elapsed >= {16'b0, cfg.sample_period};
    dt      = (elapsed > {16'b0, DT_MAX}) ? DT_MAX : elapsed[15:0];

    inc     = s0.err_mag * dt;
    acc_sum = {1'b0, integ_r} + {14'b0, inc};
    acc_new = acc_sum[48] ? ACC_MAX : acc_sum[47:0];

    kinc    = s0.ke * dt;
    if (acc_sum[48]) begin
      iterm = {cfg.int_gain, 48'b0} - {48'b0, cfg.int_gain};
    end else begin
      iterm = kiacc_r + {13'b0, kinc};
    end

    // kpe * 1000 = kpe*1024 - kpe*16 - kpe*8
    pterm    = {s0.kpe, 10'b0} - {6'b0, s0.kpe, 4'b0} - {7'b0, s0.kpe, 3'b0};
    headroom = DRIVE_LIMIT - pterm;
    sat      = s0.kpe_over || (iterm > {28'b0, headroom});

    since_toggle = s0.now - last_toggle_r;
  end

  always_comb begin
    integ_nxt       = integ_r;
    kiacc_nxt       = kiacc_r;
    last_step_nxt   = last_step_r;
    last_toggle_nxt = last_toggle_r;
    phase_nxt       = phase_r;
    sounding_nxt    = sounding_r;
    s1_nxt          = s1_r;
    s1_valid_nxt    = s1_valid_r;

    if (recalc_r) begin
      kiacc_nxt = cfg.int_gain * integ_r;
    end

    if (take) begin
      s1_valid_nxt = due;
    end else if (s1_ready) begin
      s1_valid_nxt = 1'b0;
    end

    if (take && due) begin
      last_step_nxt = s0.now;
      if (s0.err_pos) begin
        if (!sat) begin
          integ_nxt = acc_new;
          kiacc_nxt = iterm;
        end
      end else begin
        integ_nxt = 48'd0;
        kiacc_nxt = 64'd0;
      end

      if (s0.hot) begin
        if (since_toggle > {16'b0, cfg.buzzer_period}) begin
          last_toggle_nxt = s0.now;
          phase_nxt       = !phase_r;
          sounding_nxt    = !phase_r;
        end
      end else begin
        sounding_nxt = 1'b0;
      end

      s1_nxt.err_pos = s0.err_pos;
      s1_nxt.sat     = sat;
      s1_nxt.pterm   = pterm;
      s1_nxt.iterm   = iterm[35:0];
      s1_nxt.temp    = s0.temp;
      s1_nxt.status  = s0.status;
      s1_nxt.buzzer  = sounding_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r       <= 48'd0;
      kiacc_r       <= 64'd0;
      last_step_r   <= 32'd0;
      last_toggle_r <= 32'd0;
      phase_r       <= 1'b0;
      sounding_r    <= 1'b0;
      recalc_r      <= 1'b0;
      s1_valid_r    <= 1'b0;
    end else begin
      integ_r       <= integ_nxt;
      kiacc_r       <= kiacc_nxt;
      last_step_r   <= last_step_nxt;
      last_toggle_r <= last_toggle_nxt;
      phase_r       <= phase_nxt;
      sounding_r    <= sounding_nxt;
      recalc_r      <= int_gain_wr;
      s1_valid_r    <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

/* hdl/pifc_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pifc_out
// drive scaling and result register
// ----------------------------------------------------------------------------
module pifc_out (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            s1_valid,
  input  pifc_pkg::step_t s1,
  output logic            s1_ready,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_drive_pwm,
  output logic [18:0]     out_temp_q10,
  output logic [1:0]      out_band_status,
  output logic            out_buzzer_on
);
  import pifc_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  drive_r, drive_nxt;
  logic [18:0] temp_r;
  logic [1:0]  status_r;
  logic        buzzer_r;
  logic        take;
  logic [36:0] sum;
  logic [17:0] q;
  logic [36:0] quot;

  assign s1_ready = !out_valid_r || !out_stall;
  assign take     = s1_valid && s1_ready;

  always_comb begin
    // sum stays within 255 * 2^18 * 1000 when not saturated
    sum  = {1'b0, s1.pterm} + {1'b0, s1.iterm};
    q    = sum[35:18];
    quot = q * RECIP_1000;
    if (!s1.err_pos) begin
      drive_nxt = 8'd0;
    end else if (s1.sat) begin
      drive_nxt = 8'd255;
    end else begin
      drive_nxt = quot[35:28];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      drive_r  <= drive_nxt;
      temp_r   <= s1.temp;
      status_r <= s1.status;
      buzzer_r <= s1.buzzer;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_pwm   = drive_r;
  assign out_temp_q10    = temp_r;
  assign out_band_status = status_r;
  assign out_buzzer_on   = buzzer_r;

endmodule
